// ===== src/strong_connectivity_check_top_macros.svh =====
// assertion macros for the strong connectivity check
// used by strong_connectivity_check_top; no other dependencies
`ifndef STRONG_CONNECTIVITY_CHECK_TOP_MACROS_SVH
`define STRONG_CONNECTIVITY_CHECK_TOP_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SCC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define SCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/scc_pkg.sv =====
// shared types and constants for the strong connectivity check
// no dependencies
`default_nettype none

package scc_pkg;

	localparam int MAX_VERTICES = 32;
	localparam int MASK_W       = 32;
	localparam int CNT_W        = 6;
	localparam int IDX_W        = $clog2(MAX_VERTICES);
	localparam int LANES        = 4;
	localparam int LANE_ROWS    = MAX_VERTICES / LANES;

	typedef logic [LANE_ROWS-1:0][MASK_W-1:0] lane_rows_t;
	typedef logic [LANES-1:0][MASK_W-1:0]     partial_vec_t;

	typedef enum logic [1:0] {
		SCC_IDLE,
		SCC_LANE,
		SCC_MERGE
	} scc_state_t;

	// result of one frontier step
	typedef struct packed {
		logic [MASK_W-1:0] new_front;
		logic [MASK_W-1:0] new_reach;
		logic              src_done;
		logic              full;
	} merge_res_t;

	// control from the sequencer to the datapath
	typedef struct packed {
		logic lane_en;
		logic merge_en;
	} scc_ctrl_t;

endpackage

`default_nettype wire

// ===== src/scc_lane.sv =====
// one lane: ors the rows of its vertex group that lie on the frontier
// depends on scc_pkg
`default_nettype none

module scc_lane (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire scc_pkg::lane_rows_t           rows,
	input  wire logic [scc_pkg::LANE_ROWS-1:0] front,
	output logic [scc_pkg::MASK_W-1:0]         partial_s1
);

	logic [scc_pkg::MASK_W-1:0] acc;

	always_comb begin
		acc = '0;
		for (int i = 0; i < scc_pkg::LANE_ROWS; i++) begin
			if (front[i]) begin
				acc = acc | rows[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			partial_s1 <= acc;
		end
	end

endmodule

`default_nettype wire

// ===== src/scc_merge.sv =====
// merge stage: combines lane partials into the next frontier and reach set
// depends on scc_pkg
`default_nettype none

module scc_merge (
	input  wire scc_pkg::partial_vec_t       partials,
	input  wire logic [scc_pkg::MASK_W-1:0]  all_mask,
	input  wire logic [scc_pkg::MASK_W-1:0]  reach,
	output scc_pkg::merge_res_t              res
);

	logic [scc_pkg::MASK_W-1:0] next_set;

	always_comb begin
		next_set = '0;
		for (int l = 0; l < scc_pkg::LANES; l++) begin
			next_set = next_set | partials[l];
		end
		next_set      = next_set & all_mask;
		res.new_front = next_set & ~reach;
		res.new_reach = reach | res.new_front;
		res.src_done  = (res.new_front == '0);
		res.full      = (res.new_reach == all_mask);
	end

endmodule

`default_nettype wire

// ===== src/strong_connectivity_check_top.sv =====
// top level of the strong connectivity check: row store, sequencer, lanes
// depends on scc_pkg, scc_lane, scc_merge and strong_connectivity_check_top_macros.svh
`default_nettype none

// usage
//   input: start with row_index, row_mask, last_row; a transfer happens at a
//   clock edge where start is high and busy is low. every transfer stores
//   row_mask as the adjacency row of row_index
//   a row without last_row gives no result and leaves busy low; the next
//   row may follow in the next cycle
//   a row with last_row starts the check when the vertex count is nonzero; busy stays high until it ends
//   check: for each source walked, each frontier step runs the lane stage,
//   then the merge stage, including the final empty step; a source takes
//   at most n steps for n vertices; the walk stops at the first source that
//   misses a vertex
//   result: done is high for one cycle with connected; the receiver cannot
//   stall, so it must take the transfer in that cycle. with a vertex count
//   of zero the result comes in the cycle after the transfer
//   config: vertex_count_we writes vertex_count_wdata; the user must write it
//   only while idle, the block does not enforce this; counts above 32 saturate
//   reset: vertex count back to 32, sequencer idle, walk state cleared;
//   stored rows are undefined until written
`include "strong_connectivity_check_top_macros.svh"

module strong_connectivity_check_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [4:0]                  row_index,
	input  wire logic [31:0]                 row_mask,
	input  wire logic                        last_row,
	output logic                             done,
	output logic                             connected,
	input  wire logic                        vertex_count_we,
	input  wire logic [scc_pkg::CNT_W-1:0]   vertex_count_wdata
);

	// configuration and walk state
	logic [scc_pkg::CNT_W-1:0]                          vc_q;
	logic [scc_pkg::MAX_VERTICES-1:0][scc_pkg::MASK_W-1:0] rows_q;
	logic [scc_pkg::MASK_W-1:0]                         reach_q;
	logic [scc_pkg::MASK_W-1:0]                         front_q;
	logic [scc_pkg::IDX_W-1:0]                          src_q;
	logic                                               done_q;
	logic                                               connected_q;
	scc_pkg::scc_state_t                                state_q;
	scc_pkg::scc_state_t                                state_d;
	scc_pkg::scc_ctrl_t                                 ctrl;

	logic [scc_pkg::CNT_W-1:0]  used_n;
	logic [scc_pkg::MASK_W-1:0] all_mask;
	logic                       accept;
	logic                       check_go;
	logic                       last_src;
	logic                       finish;
	logic [scc_pkg::IDX_W-1:0]  src_next;
	scc_pkg::partial_vec_t      partials_s1;
	scc_pkg::merge_res_t        mres;

	// count in use saturates at the store depth
	assign used_n   = (vc_q > scc_pkg::CNT_W'(scc_pkg::MAX_VERTICES))
	                  ? scc_pkg::CNT_W'(scc_pkg::MAX_VERTICES) : vc_q;
	assign all_mask = (used_n >= scc_pkg::CNT_W'(scc_pkg::MASK_W)) ? '1
	                  : ((scc_pkg::MASK_W'(1) << used_n) - scc_pkg::MASK_W'(1));

	assign busy     = (state_q != scc_pkg::SCC_IDLE);
	assign accept   = start && !busy;
	assign check_go = accept && last_row && (used_n != '0);

	assign src_next = src_q + scc_pkg::IDX_W'(1);
	assign last_src = ((scc_pkg::CNT_W'(src_q) + scc_pkg::CNT_W'(1)) == used_n);
	// a source is finished when its frontier dies; the walk ends on a miss
	// or after the last source
	assign finish   = mres.src_done && (!mres.full || last_src);

	// row store: one write per transfer, each lane reads its own group of rows
	always_ff @(posedge clk) begin
		if (accept) begin
			rows_q[row_index[scc_pkg::IDX_W-1:0]] <= row_mask;
		end
	end

	// lanes: each covers a fixed group of rows
	for (genvar l = 0; l < scc_pkg::LANES; l++) begin : g_lane
		scc_lane u_lane (
			.clk        (clk),
			.en         (ctrl.lane_en),
			.rows       (rows_q[l*scc_pkg::LANE_ROWS +: scc_pkg::LANE_ROWS]),
			.front      (front_q[l*scc_pkg::LANE_ROWS +: scc_pkg::LANE_ROWS]),
			.partial_s1 (partials_s1[l])
		);
	end

	scc_merge u_merge (
		.partials (partials_s1),
		.all_mask (all_mask),
		.reach    (reach_q),
		.res      (mres)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			scc_pkg::SCC_IDLE: begin
				if (check_go) begin
					state_d = scc_pkg::SCC_LANE;
				end
			end
			scc_pkg::SCC_LANE: begin
				state_d = scc_pkg::SCC_MERGE;
			end
			scc_pkg::SCC_MERGE: begin
				state_d = finish ? scc_pkg::SCC_IDLE : scc_pkg::SCC_LANE;
			end
			default: begin
				state_d = scc_pkg::SCC_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		ctrl = '0;
		case (state_q)
			scc_pkg::SCC_LANE:  ctrl.lane_en  = 1'b1;
			scc_pkg::SCC_MERGE: ctrl.merge_en = 1'b1;
			default:            ctrl          = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= scc_pkg::SCC_IDLE;
			vc_q        <= scc_pkg::CNT_W'(32);
			reach_q     <= '0;
			front_q     <= '0;
			src_q       <= '0;
			done_q      <= 1'b0;
			connected_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (vertex_count_we) begin
				vc_q <= vertex_count_wdata;
			end
			if (accept && last_row && (used_n == '0)) begin
				// no sources: trivially connected
				done_q      <= 1'b1;
				connected_q <= 1'b1;
			end else if (check_go) begin
				// first source is vertex zero
				src_q   <= '0;
				reach_q <= scc_pkg::MASK_W'(1);
				front_q <= scc_pkg::MASK_W'(1);
			end else if (ctrl.merge_en) begin
				if (finish) begin
					reach_q     <= mres.new_reach;
					front_q     <= mres.new_front;
					done_q      <= 1'b1;
					connected_q <= mres.full;
				end else if (mres.src_done) begin
					// move on to the next source
					src_q   <= src_next;
					reach_q <= scc_pkg::MASK_W'(1) << src_next;
					front_q <= scc_pkg::MASK_W'(1) << src_next;
				end else begin
					reach_q <= mres.new_reach;
					front_q <= mres.new_front;
				end
			end
		end
	end

	assign done      = done_q;
	assign connected = connected_q;

	// result strobe only once the walk is over
	`SCC_ASSERT_NOW(a_done_idle, clk, arst_n, done, !busy, "result while walk still running")
	// a check with sources keeps the block busy
	`SCC_ASSERT_NEXT(a_go_busy, clk, arst_n, check_go, busy, "check did not start")
	// frontier never holds a vertex outside the reach set
	`SCC_ASSERT_NOW(a_front_in_reach, clk, arst_n, 1'b1, ((front_q & ~reach_q) == '0), "frontier outside reach set")
	// the current source is always reached during a walk
	`SCC_ASSERT_NOW(a_src_reached, clk, arst_n, busy, reach_q[src_q], "source missing from reach set")

endmodule

`default_nettype wire
